// File: hdl/wrs_pkg.sv
// Shared constants and types for the waypoint ramp stepper.
// No dependencies; every other file imports this package.
`default_nettype none
package wrs_pkg;
	localparam int WRS_POS_BITS   = 24;
	localparam int WRS_HOLD_TICKS = 20;

	localparam int ID_W      = 3;
	localparam int ACC_W     = 12;
	localparam int SPEED_W   = 12;
	localparam int TICK_W    = 8;
	localparam int CFG_IDX_W = 3;
	// quotient bits of one axis step; a step never exceeds speed/8 + 1
	localparam int Q_W       = 10;

	localparam logic [SPEED_W-1:0] SPEED_MAX      = 12'd3072;
	localparam int                 MINUS_FIVE_M   = -1280;
	localparam logic [TICK_W-1:0]  TICK_MAX       = 8'd255;
	localparam logic [TICK_W-1:0]  TICK_LEAD_HOLD = 8'd100;
	localparam logic [TICK_W-1:0]  TICK_FOL_HOLD  = 8'd70;
	// 0.3 m radius: every |d| below 77 and sum of squares at most 5898
	localparam int                 ARRIVE_MAG_LIM = 77;
	localparam logic [14:0]        ARRIVE_SQ_MAX  = 15'd5898;

	localparam logic [ID_W-1:0]  OWN_ID_RST    = 3'd1;
	localparam logic [ID_W-1:0]  LEADER_ID_RST = 3'd1;
	localparam logic [ACC_W-1:0] ACCEL_RST     = 12'd384;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OWN_ID    = 3'd0,
		REG_LEADER_ID = 3'd1,
		REG_MAX_ACCEL = 3'd2,
		REG_OFFSET_X  = 3'd3,
		REG_OFFSET_Y  = 3'd4,
		REG_OFFSET_Z  = 3'd5
	} cfg_reg_t;
endpackage
`default_nettype wire

// File: hdl/wrs_intf.sv
// Channel interfaces: tick input, setpoint output, register write port.
// Depends on wrs_pkg.
`default_nettype none
interface wrs_tick_if import wrs_pkg::*; #(parameter int POS_BITS = WRS_POS_BITS) ();
	logic                       valid;
	logic                       ready;
	logic signed [POS_BITS-1:0] leader_x;
	logic signed [POS_BITS-1:0] leader_y;
	logic signed [POS_BITS-1:0] leader_z;
	logic                       leader_seen;
	logic                       new_target;
	logic signed [POS_BITS-1:0] target_x;
	logic signed [POS_BITS-1:0] target_y;
	logic signed [POS_BITS-1:0] target_z;
	modport source (output valid, leader_x, leader_y, leader_z, leader_seen, new_target,
		target_x, target_y, target_z, input ready);
	modport sink (input valid, leader_x, leader_y, leader_z, leader_seen, new_target,
		target_x, target_y, target_z, output ready);
endinterface

interface wrs_set_if import wrs_pkg::*; #(parameter int POS_BITS = WRS_POS_BITS) ();
	logic                       valid;
	logic                       ready;
	logic signed [POS_BITS-1:0] set_x;
	logic signed [POS_BITS-1:0] set_y;
	logic signed [POS_BITS-1:0] set_z;
	logic                       arrived;
	modport source (output valid, set_x, set_y, set_z, arrived, input ready);
	modport sink (input valid, set_x, set_y, set_z, arrived, output ready);
endinterface

interface wrs_cfg_if import wrs_pkg::*; #(parameter int POS_BITS = WRS_POS_BITS) ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [POS_BITS-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/wrs_isqrt.sv
// Bit-serial floor square root, two radicand bits per cycle.
// Depends on wrs_pkg.
`default_nettype none
module wrs_isqrt import wrs_pkg::*; #(
	parameter int SQ_W = 52
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [SQ_W-1:0] x,
	output logic                 done,
	output logic [SQ_W-1:0]      root
);
	logic [SQ_W-1:0] x_q, r_q, bit_q, rb;
	logic            busy_q, done_q;

	assign rb = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			r_q   <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy_q) begin
			if (x_q >= rb) begin
				x_q <= x_q - rb;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q;
endmodule
`default_nettype wire

// File: hdl/wrs_div.sv
// Bit-serial rounded step: q = round(mag*speed / (8*span)), one quotient bit per cycle.
// Depends on wrs_pkg.
`default_nettype none
module wrs_div import wrs_pkg::*; #(
	parameter int MAG_W = 25
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [MAG_W-1:0]   mag,
	input  wire logic [SPEED_W-1:0] speed,
	input  wire logic [MAG_W:0]     span,
	output logic                    done,
	output logic [Q_W-1:0]          quo
);
	localparam int CW    = MAG_W + 14;
	localparam int CNT_W = $clog2(Q_W + 1);

	logic [CW-1:0]    rem_q, dv_q;
	logic [Q_W-1:0]   q_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// (2n + d) / 2d with d = 8*span equals (n + 4*span) / (8*span)
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= CW'(mag * speed) + (CW'(span) << 2);
			dv_q  <= CW'(span) << (Q_W + 2);
			q_q   <= '0;
		end else if (busy_q) begin
			if (rem_q >= dv_q) begin
				rem_q <= rem_q - dv_q;
				q_q   <= {q_q[Q_W-2:0], 1'b1};
			end else begin
				q_q   <= {q_q[Q_W-2:0], 1'b0};
			end
			dv_q <= dv_q >> 1;
		end
	end

	assign done = done_q;
	assign quo  = q_q;
endmodule
`default_nettype wire

// File: hdl/waypoint_ramp_stepper.sv
// Waypoint ramp stepper: one tick transaction in, one setpoint transaction out.
// Depends on wrs_pkg, wrs_intf, wrs_isqrt, wrs_div.
//
// Each tick is worked on alone. Follower ticks, early ticks and ticks with no
// active waypoint pass from acceptance through the load of the output register
// in the steps capture, evaluate and load; arrival and hold ticks add a decide
// step before the load. A moving tick adds sum-of-squares accumulation, one
// axis at a time on one shared multiplier, a bit-serial square root (two
// radicand bits per cycle; above 30 bits the deltas are pre-scaled) and, per
// axis, a bit-serial divide. A new tick is taken once the previous result is in
// the output register, even while that result still waits on setpoint.ready.
// The register port is always ready and must only be written while the block
// is idle.
`default_nettype none
module waypoint_ramp_stepper import wrs_pkg::*; #(
	parameter int POS_BITS   = WRS_POS_BITS,
	parameter int HOLD_TICKS = WRS_HOLD_TICKS
) (
	input wire logic   clk,
	input wire logic   arst_n,
	wrs_tick_if.sink   tick,
	wrs_set_if.source  setpoint,
	wrs_cfg_if.sink    cfg
);
	localparam int MAG_W  = POS_BITS + 1;
	localparam int SM_W   = (MAG_W > 31) ? 31 : MAG_W;
	localparam int SQ_W   = 2 * SM_W + 2;
	localparam int DIST_W = MAG_W + 1;
	localparam int HOLD_W = $clog2(HOLD_TICKS + 2);
	localparam int SUM_W  = POS_BITS + 2;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_EVAL   = 8'b0000_0010,
		ST_CHK    = 8'b0000_0100,
		ST_SQR    = 8'b0000_1000,
		ST_ROOT   = 8'b0001_0000,
		ST_DSTART = 8'b0010_0000,
		ST_DWAIT  = 8'b0100_0000,
		ST_FIN    = 8'b1000_0000
	} state_t;

	function automatic logic [POS_BITS-1:0] sat_pos(input logic [SUM_W-1:0] v);
		logic [POS_BITS-1:0] r;
		if (v[SUM_W-1] == v[SUM_W-2] && v[SUM_W-1] == v[POS_BITS-1])
			r = v[POS_BITS-1:0];
		else if (v[SUM_W-1])
			r = {1'b1, {(POS_BITS-1){1'b0}}};
		else
			r = {1'b0, {(POS_BITS-1){1'b1}}};
		return r;
	endfunction

	state_t state_q;

	// configuration
	logic [ID_W-1:0]     own_id_q, leader_id_q;
	logic [ACC_W-1:0]    accel_q;
	logic [POS_BITS-1:0] off_q [3];

	// persistent state
	logic [TICK_W-1:0]   tick_cnt_q;
	logic                goal_act_q, motion_q;
	logic [POS_BITS-1:0] goal_q [3];
	logic [SPEED_W-1:0]  speed_q;
	logic [HOLD_W-1:0]   hold_q;

	// per-tick working registers
	logic [POS_BITS-1:0] lpos_q [3];
	logic                lead_role_q, early_lead_q, early_fol_q;
	logic [MAG_W-1:0]    mag_q [3];
	logic                neg_q [3];
	logic [SM_W-1:0]     sm_q [3];
	logic [1:0]          sh_q, ax_q;
	logic [SQ_W-1:0]     acc_q;
	logic [DIST_W-1:0]   dist_q;
	logic [POS_BITS-1:0] res_q [3];
	logic                res_arr_q;

	// output register
	logic                oval_q;
	logic [POS_BITS-1:0] oset_q [3];
	logic                oarr_q;

	logic                accept, same_id, out_load;
	logic [SQ_W-1:0]     acc_next;
	logic                sqrt_done, div_done;
	logic [SQ_W-1:0]     sqrt_root;
	logic [Q_W-1:0]      div_q;
	logic [DIST_W-1:0]   dist_c;
	logic [MAG_W-1:0]    orv;
	logic [1:0]          sh_c;
	logic                near;
	logic [14:0]         sq_sum;
	logic [SUM_W-1:0]    step_sum;
	logic [SUM_W-1:0]    step_v;

	assign same_id   = (own_id_q == leader_id_q);
	assign accept    = tick.valid && tick.ready;
	assign tick.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign out_load  = (state_q == ST_FIN) && (!oval_q || setpoint.ready);

	assign setpoint.valid   = oval_q;
	assign setpoint.set_x   = oset_q[0];
	assign setpoint.set_y   = oset_q[1];
	assign setpoint.set_z   = oset_q[2];
	assign setpoint.arrived = oarr_q;

	// shared squarer: one axis per cycle
	assign acc_next = acc_q + SQ_W'(sm_q[ax_q] * sm_q[ax_q]);

	// normalizing shift when a delta does not fit in 31 bits
	always_comb begin
		orv  = mag_q[0] | mag_q[1] | mag_q[2];
		sh_c = 2'd0;
		for (int k = 31; k < MAG_W; k++)
			if (orv[k]) sh_c = 2'(k - 30);
	end

	always_comb begin
		near = 1'b1;
		for (int i = 0; i < 3; i++)
			if (mag_q[i] >= MAG_W'(ARRIVE_MAG_LIM)) near = 1'b0;
		sq_sum = 15'(mag_q[0][6:0] * mag_q[0][6:0]) + 15'(mag_q[1][6:0] * mag_q[1][6:0])
			+ 15'(mag_q[2][6:0] * mag_q[2][6:0]);
	end

	always_comb begin
		dist_c = DIST_W'(sqrt_root[SM_W:0]) << sh_q;
		if (dist_c == '0) dist_c = DIST_W'(1);
	end

	always_comb begin
		step_v = SUM_W'(div_q);
		if (neg_q[ax_q]) step_v = -step_v;
		step_sum = SUM_W'(signed'(lpos_q[ax_q])) + step_v;
	end

	wrs_isqrt #(.SQ_W(SQ_W)) u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start ((state_q == ST_SQR) && (ax_q == 2'd2)),
		.x     (acc_next),
		.done  (sqrt_done),
		.root  (sqrt_root)
	);

	wrs_div #(.MAG_W(MAG_W)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (state_q == ST_DSTART),
		.mag   (mag_q[ax_q]),
		.speed (speed_q),
		.span  (dist_q),
		.done  (div_done),
		.quo   (div_q)
	);

	// register port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q    <= OWN_ID_RST;
			leader_id_q <= LEADER_ID_RST;
			accel_q     <= ACCEL_RST;
			off_q[0]    <= '0;
			off_q[1]    <= '0;
			off_q[2]    <= '0;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_OWN_ID:    own_id_q    <= cfg.data[ID_W-1:0];
				REG_LEADER_ID: leader_id_q <= cfg.data[ID_W-1:0];
				REG_MAX_ACCEL: accel_q     <= cfg.data[ACC_W-1:0];
				REG_OFFSET_X:  off_q[0]    <= cfg.data;
				REG_OFFSET_Y:  off_q[1]    <= cfg.data;
				REG_OFFSET_Z:  off_q[2]    <= cfg.data;
				default: ;
			endcase
		end
	end

	// control and persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tick_cnt_q <= '0;
			goal_act_q <= 1'b0;
			goal_q[0]  <= '0;
			goal_q[1]  <= '0;
			goal_q[2]  <= '0;
			speed_q    <= '0;
			motion_q   <= 1'b0;
			hold_q     <= '0;
			ax_q       <= '0;
			oval_q     <= 1'b0;
		end else begin
			if (out_load)
				oval_q <= 1'b1;
			else if (setpoint.ready)
				oval_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (tick.new_target && same_id) begin
							goal_q[0]  <= tick.target_x;
							goal_q[1]  <= tick.target_y;
							goal_q[2]  <= tick.target_z;
							goal_act_q <= 1'b1;
						end
						if (tick_cnt_q != TICK_MAX) tick_cnt_q <= tick_cnt_q + 1'b1;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (!lead_role_q || early_lead_q || !goal_act_q)
						state_q <= ST_FIN;
					else
						state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (near && sq_sum <= ARRIVE_SQ_MAX) begin
						speed_q    <= '0;
						motion_q   <= 1'b0;
						goal_act_q <= 1'b0;
						state_q    <= ST_FIN;
					end else if (!motion_q) begin
						if (hold_q >= HOLD_W'(HOLD_TICKS)) motion_q <= 1'b1;
						if (hold_q < HOLD_W'(HOLD_TICKS + 1)) hold_q <= hold_q + 1'b1;
						state_q <= ST_FIN;
					end else begin
						if (speed_q < SPEED_MAX) begin
							if (13'(speed_q) + 13'(accel_q >> 3) > 13'(SPEED_MAX))
								speed_q <= SPEED_MAX;
							else
								speed_q <= speed_q + SPEED_W'(accel_q >> 3);
						end
						ax_q    <= '0;
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					if (ax_q == 2'd2) begin
						state_q <= ST_ROOT;
					end else begin
						ax_q <= ax_q + 1'b1;
					end
				end
				ST_ROOT: begin
					if (sqrt_done) begin
						ax_q    <= '0;
						state_q <= ST_DSTART;
					end
				end
				ST_DSTART: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (div_done) begin
						if (ax_q == 2'd2) begin
							state_q <= ST_FIN;
						end else begin
							ax_q    <= ax_q + 1'b1;
							state_q <= ST_DSTART;
						end
					end
				end
				ST_FIN: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					lpos_q[0]    <= tick.leader_seen ? tick.leader_x : '0;
					lpos_q[1]    <= tick.leader_seen ? tick.leader_y : '0;
					lpos_q[2]    <= tick.leader_seen ? tick.leader_z : '0;
					lead_role_q  <= same_id || !tick.leader_seen;
					early_lead_q <= (tick_cnt_q <= TICK_LEAD_HOLD);
					early_fol_q  <= (tick_cnt_q <= TICK_FOL_HOLD);
				end
			end
			ST_EVAL: begin
				res_arr_q <= 1'b0;
				for (int i = 0; i < 3; i++) begin
					logic [MAG_W-1:0] d;
					d = MAG_W'(signed'(goal_q[i])) - MAG_W'(signed'(lpos_q[i]));
					neg_q[i] <= d[MAG_W-1];
					mag_q[i] <= d[MAG_W-1] ? -d : d;
					res_q[i] <= lpos_q[i];
				end
				if (!lead_role_q) begin
					if (early_fol_q) begin
						res_q[0] <= '0;
						res_q[1] <= '0;
						res_q[2] <= POS_BITS'(MINUS_FIVE_M);
					end else begin
						for (int i = 0; i < 3; i++)
							res_q[i] <= sat_pos(SUM_W'(signed'(lpos_q[i]))
								+ SUM_W'(signed'(off_q[i])));
					end
				end else if (early_lead_q) begin
					res_q[2] <= POS_BITS'(MINUS_FIVE_M);
				end
			end
			ST_CHK: begin
				if (near && sq_sum <= ARRIVE_SQ_MAX) begin
					res_q[0]  <= goal_q[0];
					res_q[1]  <= goal_q[1];
					res_q[2]  <= goal_q[2];
					res_arr_q <= 1'b1;
				end
				for (int i = 0; i < 3; i++)
					sm_q[i] <= SM_W'(mag_q[i] >> sh_c);
				sh_q  <= sh_c;
				acc_q <= '0;
			end
			ST_SQR: acc_q <= acc_next;
			ST_ROOT: begin
				if (sqrt_done) dist_q <= dist_c;
			end
			ST_DWAIT: begin
				if (div_done) res_q[ax_q] <= sat_pos(step_sum);
			end
			default: ;
		endcase
		if (out_load) begin
			oset_q[0] <= res_q[0];
			oset_q[1] <= res_q[1];
			oset_q[2] <= res_q[2];
			oarr_q    <= res_arr_q;
		end
	end
endmodule
`default_nettype wire

// File: hdl/wrs_checker.sv
// Port-level checks for waypoint_ramp_stepper, bound to the top level.
// Depends on wrs_pkg and waypoint_ramp_stepper.
`default_nettype none
module wrs_checker import wrs_pkg::*; #(
	parameter int POS_BITS = WRS_POS_BITS
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                tick_valid,
	input wire logic                tick_ready,
	input wire logic                set_valid,
	input wire logic                set_ready,
	input wire logic [POS_BITS-1:0] set_x,
	input wire logic                arrived,
	input wire logic                cfg_ready
);
	// a result waiting on the sink keeps its x coordinate and arrived flag
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		set_valid && !set_ready |=> set_valid && $stable(set_x) && $stable(arrived))
		else $error("setpoint transaction changed while stalled");

	// one tick in flight at a time
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && tick_ready |=> !tick_ready)
		else $error("tick accepted while previous tick still in work");

	// a result does not appear directly after the acceptance of its tick
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(set_valid) |-> !$past(tick_valid && tick_ready))
		else $error("setpoint appeared too soon after tick");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("register port not ready");
endmodule

bind waypoint_ramp_stepper wrs_checker #(.POS_BITS(POS_BITS)) u_wrs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.tick_valid(tick.valid),
	.tick_ready(tick.ready),
	.set_valid (setpoint.valid),
	.set_ready (setpoint.ready),
	.set_x     (setpoint.set_x),
	.arrived   (setpoint.arrived),
	.cfg_ready (cfg.ready)
);
`default_nettype wire
